// ===== sv/acep_pkg.sv =====
// ----------------------------------------------------------------------------
// acep_pkg
// Shared constants and helpers for the ANSI color escape parser.
// ----------------------------------------------------------------------------
package acep_pkg;

   localparam int ByteWidth  = 8;
   localparam int AttrWidth  = 16;
   localparam int ColorWidth = 4;
   localparam int BurstDepth = 6;               // longest flush: ESC [ 1 0 d + offending byte
   localparam int CountWidth = $clog2(BurstDepth + 1);

   // result kinds
   localparam logic KindText = 1'b0;
   localparam logic KindAttr = 1'b1;

   // bytes of the escape grammar
   localparam logic [ByteWidth-1:0] EscByte      = 8'h1B;
   localparam logic [ByteWidth-1:0] CharLBracket = 8'h5B;
   localparam logic [ByteWidth-1:0] CharM        = 8'h6D;
   localparam logic [ByteWidth-1:0] CharZero     = 8'h30;
   localparam logic [ByteWidth-1:0] CharOne      = 8'h31;
   localparam logic [ByteWidth-1:0] CharThree    = 8'h33;
   localparam logic [ByteWidth-1:0] CharFour     = 8'h34;
   localparam logic [ByteWidth-1:0] CharSeven    = 8'h37;
   localparam logic [ByteWidth-1:0] CharNine     = 8'h39;

   // color group codes: bit 1 set means background
   localparam logic [1:0] GrpFg      = 2'd0;   // "3"
   localparam logic [1:0] GrpFgBright = 2'd1;  // "9"
   localparam logic [1:0] GrpBg      = 2'd2;   // "4"
   localparam logic [1:0] GrpBgBright = 2'd3;  // "10"

   // SGR digit to console color: console bits are blue, green, red, so the
   // digit's red/green/blue order reverses; bright adds the intensity bit.
   function automatic logic [ColorWidth-1:0] color_map(input logic bright,
                                                       input logic [2:0] digit);
      color_map = {bright, digit[0], digit[1], digit[2]};
   endfunction

endpackage

// ===== sv/ansi_color_escape_parser.sv =====
// ----------------------------------------------------------------------------
// ansi_color_escape_parser
// Text stream filter that turns ANSI SGR color sequences into console
// attribute word writes and passes all other bytes through.
// ----------------------------------------------------------------------------
// One byte is taken per cycle while req_stall is low. The parse step runs in
// the same cycle as the accept and loads an output burst register with every
// result the byte causes; that register drains one result per cycle unless
// rsp_stall holds it. A byte with a single result (plain text, a finished
// color sequence) therefore lets bytes stream back to back. A broken
// sequence flushes its prefix plus the offending byte, up to 6 results, and
// req_stall stays high until the burst is on its last result. ESC from idle,
// and the inner bytes of a sequence, produce nothing. rsp_last marks the
// final result of each byte. The base attribute word is captured from
// req_console_attr on the first color set after reset or after ESC[0m;
// ESC[0m itself writes back the saved base word.
module ansi_color_escape_parser (
   input  logic                                clock,
   input  logic                                reset,
   // byte stream in
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [acep_pkg::ByteWidth-1:0]      req_data_byte,
   input  logic [acep_pkg::AttrWidth-1:0]      req_console_attr,
   // results out
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_kind,
   output logic [acep_pkg::ByteWidth-1:0]      rsp_out_byte,
   output logic [acep_pkg::AttrWidth-1:0]      rsp_attr_word,
   output logic                                rsp_last
);

   typedef enum logic [3:0] {
      IDLE,       // plain text
      ESC_SEEN,   // ESC
      BRACKET,    // ESC[
      GRP3,       // ESC[3
      GRP4,       // ESC[4
      GRP9,       // ESC[9
      GRP1,       // ESC[1
      GRP10,      // ESC[10
      ZERO,       // ESC[0
      DIGIT       // ESC[<group><digit>, waiting for 'm'
   } phase_type;

   // parser state
   phase_type                           phase_ff, phase_in;
   logic [1:0]                          grp_ff, grp_in;
   logic [2:0]                          digit_ff, digit_in;
   logic [acep_pkg::ColorWidth-1:0]     color_ff, color_in;
   logic                                bg_ff, bg_in;
   logic [acep_pkg::AttrWidth-1:0]      base_ff, base_in;
   logic                                capture_ff, capture_in;

   // output burst register
   logic [acep_pkg::CountWidth-1:0]     bst_count_ff;
   logic                                bst_kind_ff;
   logic [acep_pkg::AttrWidth-1:0]      bst_attr_ff;
   logic [acep_pkg::ByteWidth-1:0]      bst_bytes_ff [acep_pkg::BurstDepth];

   // burst produced by the byte at the input
   logic [acep_pkg::CountWidth-1:0]     load_count;
   logic                                load_kind;
   logic [acep_pkg::AttrWidth-1:0]      load_attr;
   logic [acep_pkg::ByteWidth-1:0]      load_bytes [acep_pkg::BurstDepth];

   // flush prefix of the current partial sequence
   logic [acep_pkg::CountWidth-1:0]     pre_len;
   logic [acep_pkg::ByteWidth-1:0]      pre_bytes [acep_pkg::BurstDepth-1];

   logic                                fail;
   logic                                bright;
   logic [acep_pkg::ByteWidth-1:0]      digit_lo;
   logic [acep_pkg::AttrWidth-1:0]      base_sel;
   logic [acep_pkg::ByteWidth-1:0]      c;
   logic                                req_fire;
   logic                                rsp_fire;

   assign c        = req_data_byte;
   assign rsp_fire = rsp_valid && !rsp_stall;
   assign req_fire = req_valid && !req_stall;

   // Take a new byte when the burst is empty or its last result leaves now.
   assign req_stall = (bst_count_ff != '0) &&
                      !((bst_count_ff == acep_pkg::CountWidth'(1)) && !rsp_stall);

   assign rsp_valid     = (bst_count_ff != '0);
   assign rsp_last      = (bst_count_ff == acep_pkg::CountWidth'(1));
   assign rsp_kind      = bst_kind_ff;
   assign rsp_out_byte  = bst_bytes_ff[0];
   assign rsp_attr_word = bst_attr_ff;

   // Bright groups start at digit 1.
   assign bright   = (phase_ff == GRP9) || (phase_ff == GRP10);
   assign digit_lo = bright ? acep_pkg::CharOne : acep_pkg::CharZero;
   // Capture console_attr as base on the first set after reset or ESC[0m.
   assign base_sel = capture_ff ? req_console_attr : base_ff;

   // Prefix bytes already swallowed by the parser, replayed on a mismatch.
   always_comb begin
      pre_bytes[0] = acep_pkg::EscByte;
      pre_bytes[1] = acep_pkg::CharLBracket;
      pre_bytes[2] = '0;
      pre_bytes[3] = '0;
      pre_bytes[4] = '0;
      pre_len      = '0;
      unique case (phase_ff)
         ESC_SEEN: pre_len = acep_pkg::CountWidth'(1);
         BRACKET:  pre_len = acep_pkg::CountWidth'(2);
         GRP3: begin
            pre_len      = acep_pkg::CountWidth'(3);
            pre_bytes[2] = acep_pkg::CharThree;
         end
         GRP4: begin
            pre_len      = acep_pkg::CountWidth'(3);
            pre_bytes[2] = acep_pkg::CharFour;
         end
         GRP9: begin
            pre_len      = acep_pkg::CountWidth'(3);
            pre_bytes[2] = acep_pkg::CharNine;
         end
         GRP1: begin
            pre_len      = acep_pkg::CountWidth'(3);
            pre_bytes[2] = acep_pkg::CharOne;
         end
         ZERO: begin
            pre_len      = acep_pkg::CountWidth'(3);
            pre_bytes[2] = acep_pkg::CharZero;
         end
         GRP10: begin
            pre_len      = acep_pkg::CountWidth'(4);
            pre_bytes[2] = acep_pkg::CharOne;
            pre_bytes[3] = acep_pkg::CharZero;
         end
         DIGIT: begin
            unique case (grp_ff)
               acep_pkg::GrpFg:       pre_bytes[2] = acep_pkg::CharThree;
               acep_pkg::GrpFgBright: pre_bytes[2] = acep_pkg::CharNine;
               acep_pkg::GrpBg:       pre_bytes[2] = acep_pkg::CharFour;
               default:               pre_bytes[2] = acep_pkg::CharOne;
            endcase
            if (grp_ff == acep_pkg::GrpBgBright) begin
               pre_len      = acep_pkg::CountWidth'(5);
               pre_bytes[3] = acep_pkg::CharZero;
               pre_bytes[4] = acep_pkg::CharZero | {5'd0, digit_ff};
            end else begin
               pre_len      = acep_pkg::CountWidth'(4);
               pre_bytes[3] = acep_pkg::CharZero | {5'd0, digit_ff};
            end
         end
         default: pre_len = '0;
      endcase
   end

   // Parse step for the byte at the input.
   always_comb begin
      phase_in   = IDLE;
      grp_in     = grp_ff;
      digit_in   = digit_ff;
      color_in   = color_ff;
      bg_in      = bg_ff;
      base_in    = base_ff;
      capture_in = capture_ff;
      fail       = 1'b0;
      load_count = '0;
      load_kind  = acep_pkg::KindText;
      load_attr  = '0;
      for (int i = 0; i < acep_pkg::BurstDepth; i++) begin
         load_bytes[i] = '0;
      end

      unique case (phase_ff)
         ESC_SEEN: begin
            if (c == acep_pkg::CharLBracket) begin
               phase_in = BRACKET;
            end else if (c == acep_pkg::EscByte) begin
               // emit the first ESC, stay armed on the second
               phase_in      = ESC_SEEN;
               load_count    = acep_pkg::CountWidth'(1);
               load_bytes[0] = acep_pkg::EscByte;
            end else begin
               fail = 1'b1;
            end
         end
         BRACKET: begin
            priority if (c == acep_pkg::CharThree) phase_in = GRP3;
            else if (c == acep_pkg::CharFour)       phase_in = GRP4;
            else if (c == acep_pkg::CharNine)       phase_in = GRP9;
            else if (c == acep_pkg::CharOne)        phase_in = GRP1;
            else if (c == acep_pkg::CharZero)       phase_in = ZERO;
            else                                    fail     = 1'b1;
         end
         GRP1: begin
            if (c == acep_pkg::CharZero) begin
               phase_in = GRP10;
            end else begin
               fail = 1'b1;
            end
         end
         GRP3, GRP4, GRP9, GRP10: begin
            if ((c >= digit_lo) && (c <= acep_pkg::CharSeven)) begin
               unique case (phase_ff)
                  GRP3:    grp_in = acep_pkg::GrpFg;
                  GRP9:    grp_in = acep_pkg::GrpFgBright;
                  GRP4:    grp_in = acep_pkg::GrpBg;
                  default: grp_in = acep_pkg::GrpBgBright;
               endcase
               phase_in = DIGIT;
               digit_in = c[2:0];
               color_in = acep_pkg::color_map(bright, c[2:0]);
               bg_in    = (phase_ff == GRP4) || (phase_ff == GRP10);
            end else begin
               fail = 1'b1;
            end
         end
         ZERO: begin
            if (c == acep_pkg::CharM) begin
               // reset to base and re-arm the capture
               capture_in = 1'b1;
               load_count = acep_pkg::CountWidth'(1);
               load_kind  = acep_pkg::KindAttr;
               load_attr  = base_ff;
            end else begin
               fail = 1'b1;
            end
         end
         DIGIT: begin
            if (c == acep_pkg::CharM) begin
               base_in    = base_sel;
               capture_in = 1'b0;
               load_count = acep_pkg::CountWidth'(1);
               load_kind  = acep_pkg::KindAttr;
               if (bg_ff) begin
                  load_attr = {4'd0, color_ff, base_sel[7:0]};
               end else begin
                  load_attr = {base_sel[15:8], 4'd0, color_ff};
               end
            end else begin
               fail = 1'b1;
            end
         end
         default: begin
            // idle: start a sequence on ESC, pass anything else
            if (c == acep_pkg::EscByte) begin
               phase_in = ESC_SEEN;
            end else begin
               load_count    = acep_pkg::CountWidth'(1);
               load_bytes[0] = c;
            end
         end
      endcase

      // Mismatch: replay the prefix, then the offending byte, and drop to idle.
      if (fail) begin
         phase_in   = IDLE;
         load_count = pre_len + acep_pkg::CountWidth'(1);
         for (int i = 0; i < acep_pkg::BurstDepth; i++) begin
            if (i < acep_pkg::BurstDepth - 1 && acep_pkg::CountWidth'(i) < pre_len) begin
               load_bytes[i] = pre_bytes[i < acep_pkg::BurstDepth - 1 ? i : 0];
            end else if (acep_pkg::CountWidth'(i) == pre_len) begin
               load_bytes[i] = c;
            end
         end
      end
   end

   // State and burst register.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= IDLE;
         grp_ff       <= '0;
         digit_ff     <= '0;
         color_ff     <= '0;
         bg_ff        <= 1'b0;
         base_ff      <= '0;
         capture_ff   <= 1'b1;
         bst_count_ff <= '0;
      end else begin
         if (req_fire) begin
            phase_ff   <= phase_in;
            grp_ff     <= grp_in;
            digit_ff   <= digit_in;
            color_ff   <= color_in;
            bg_ff      <= bg_in;
            base_ff    <= base_in;
            capture_ff <= capture_in;
         end
         if (req_fire && (load_count != '0)) begin
            // load a fresh burst; the old one is empty or leaving now
            bst_count_ff <= load_count;
            bst_kind_ff  <= load_kind;
            bst_attr_ff  <= load_attr;
            for (int i = 0; i < acep_pkg::BurstDepth; i++) begin
               bst_bytes_ff[i] <= load_bytes[i];
            end
         end else if (rsp_fire) begin
            // advance to the next result of the burst
            bst_count_ff <= bst_count_ff - acep_pkg::CountWidth'(1);
            for (int i = 0; i < acep_pkg::BurstDepth - 1; i++) begin
               bst_bytes_ff[i] <= bst_bytes_ff[i + 1];
            end
            bst_bytes_ff[acep_pkg::BurstDepth - 1] <= '0;
         end
      end
   end

endmodule

// ===== sv/acep_checker.sv =====
// ----------------------------------------------------------------------------
// acep_checker
// Port-level checks for the ANSI color escape parser.
// ----------------------------------------------------------------------------
module acep_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic [acep_pkg::ByteWidth-1:0]      req_data_byte,
   input logic [acep_pkg::AttrWidth-1:0]      req_console_attr,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic                                rsp_kind,
   input logic [acep_pkg::ByteWidth-1:0]      rsp_out_byte,
   input logic [acep_pkg::AttrWidth-1:0]      rsp_attr_word,
   input logic                                rsp_last
);

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kind) &&
      $stable(rsp_out_byte) && $stable(rsp_attr_word) && $stable(rsp_last))
      else $error("stalled result changed");

   // attribute writes are single results with a zero text byte
   a_attr_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == acep_pkg::KindAttr) |-> rsp_last && (rsp_out_byte == '0))
      else $error("attribute result malformed");

   // text results carry no attribute word
   a_text_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == acep_pkg::KindText) |-> (rsp_attr_word == '0))
      else $error("text result carries attribute bits");

   // a burst continues until its last result
   a_burst_cont: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last && !rsp_stall |=> rsp_valid)
      else $error("burst ended early");

   // no new input while a burst still has more than the current result
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> req_stall)
      else $error("input taken in mid burst");

endmodule

bind ansi_color_escape_parser acep_checker u_acep_checker (.*);
